// ===== hdl/sctt_pkg.sv =====
// ----------------------------------------------------------------------------
// sctt_pkg
// Shared types, fixed-point constants and factorial helpers for the
// sine / cosine / tangent unit.
// ----------------------------------------------------------------------------
`default_nettype none

package sctt_pkg;

  // Series length (terms of each Taylor sum)
  localparam int SERIES_TERMS = 4;

  // Field and datapath widths
  localparam int ANGLE_W  = 32;             // Q5.26 input angle
  localparam int VALUE_W  = 48;             // Q17.30 result
  localparam int RED_W    = 62;             // Q.56 reduction word
  localparam int X_W      = 30;             // folded angle, Q.30
  localparam int POW_W    = 31;             // series powers, Q.30 up to 1.0
  localparam int SUM_W    = 33;             // signed series sum
  localparam int MAG_W    = SUM_W - 1;      // magnitude of a sum
  localparam int NUM_W    = MAG_W + 30;     // tangent dividend
  localparam int DIV_STEP = 2;              // quotient bits per divider stage
  localparam int DIV_STAGES = NUM_W / DIV_STEP;

  localparam int FRONT_STAGES = 8;
  localparam int QUEUE_DEPTH  = 4;
  localparam int QPTR_W       = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W       = $clog2(QUEUE_DEPTH + 1);

  // Angle constants in Q.56; pi/2 rounded, the rest derived from it
  localparam logic [63:0] PI_Q60    = 64'h3243F6A8885A308D;
  localparam logic [63:0] HALF_PI64 = (PI_Q60 + 64'd16) >> 5;
  localparam logic [RED_W-1:0] HALF_PI       = HALF_PI64[RED_W-1:0];
  localparam logic [RED_W-1:0] QUARTER_PI    = HALF_PI >> 1;
  localparam logic [RED_W-1:0] ONE_PI        = RED_W'(HALF_PI64 * 64'd2);
  localparam logic [RED_W-1:0] THREE_HALF_PI = RED_W'(HALF_PI64 * 64'd3);
  localparam logic [RED_W-1:0] TWO_PI        = RED_W'(HALF_PI64 * 64'd4);

  localparam logic [POW_W-1:0] ONE_Q30 = POW_W'(64'd1 << 30);

  localparam logic [VALUE_W-1:0] VAL_MAX = {1'b0, {(VALUE_W-1){1'b1}}};
  localparam logic [VALUE_W-1:0] VAL_MIN = {1'b1, {(VALUE_W-1){1'b0}}};

  // Request codes
  typedef enum logic [1:0] {
    REQ_SIN  = 2'd0,
    REQ_COS  = 2'd1,
    REQ_TAN  = 2'd2,
    REQ_NONE = 2'd3
  } sctt_req_t;

  // Item handed from the front end to the series back end
  typedef struct packed {
    sctt_req_t        req;
    logic             swap;     // above pi/4: use the complementary series
    logic             sin_neg;
    logic             cos_neg;
    logic [X_W-1:0]   x;
  } sctt_item_t;

  // n! (elaboration only)
  function automatic longint unsigned fact(input int n);
    longint unsigned f;
    f = 64'd1;
    for (int i = 2; i <= n; i++) f = f * longint'(i);
    return f;
  endfunction

  // Number of trailing zero bits of n!
  function automatic int fact_tz(input int n);
    longint unsigned f;
    int              z;
    f = fact(n);
    z = 0;
    for (int i = 0; i < 63; i++) begin
      if (f[0] == 1'b0) begin
        f = f >> 1;
        z = z + 1;
      end
    end
    return z;
  endfunction

endpackage

`default_nettype wire

// ===== hdl/sctt_front.sv =====
// ----------------------------------------------------------------------------
// sctt_front
// Front end: angle reduction modulo two pi, quadrant fold and octant swap,
// rounding to Q.30. Hands one classified item per cycle to a non-full queue.
// ----------------------------------------------------------------------------
`default_nettype none

module sctt_front
  import sctt_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire logic [1:0]          in_req_type,
  input  wire logic [ANGLE_W-1:0]  in_angle,
  input  wire logic                q_full,
  output logic                     push,
  output sctt_item_t               push_item
);

  logic [FRONT_STAGES-1:0] v_r;
  logic                    en;

  sctt_req_t        req_r [FRONT_STAGES-1];
  logic             neg_r [4];
  logic [RED_W-1:0] red_r [5];
  logic [RED_W-1:0] fx_r, y_r;
  logic             sn_r [2];
  logic             cn_r [2];
  logic             swap_r;
  sctt_item_t       item_r;

  logic [ANGLE_W-1:0] mag;
  logic               ang_neg;
  logic [RED_W-1:0]   red_nxt [3];
  logic [RED_W-1:0]   rr_nxt;
  logic [RED_W-1:0]   fx_nxt;
  logic               sn_nxt, cn_nxt;
  logic [RED_W-1:0]   y_nxt;
  logic               swap_nxt;
  logic [RED_W-1:0]   rnd;

  // Whole front end holds while its last item cannot enter the queue
  assign en        = !(v_r[FRONT_STAGES-1] && q_full);
  assign in_ready  = en;
  assign push      = v_r[FRONT_STAGES-1] && !q_full;
  assign push_item = item_r;

  // Valid pipeline
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[FRONT_STAGES-2:0], in_valid};
    end
  end

  // Magnitude of the angle, scaled to Q.56
  always_comb begin
    ang_neg = in_angle[ANGLE_W-1];
    mag     = ang_neg ? (ANGLE_W'(0) - in_angle) : in_angle;
  end

  // Subtract 4, 2, then 1 times two pi (quotient is at most five)
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      if (red_r[i] >= (TWO_PI << (2 - i))) red_nxt[i] = red_r[i] - (TWO_PI << (2 - i));
      else red_nxt[i] = red_r[i];
    end
  end

  // Negative angles take the true modulo
  always_comb begin
    if (neg_r[3] && (red_r[3] != '0)) rr_nxt = TWO_PI - red_r[3];
    else rr_nxt = red_r[3];
  end

  // Fold to the first quadrant, record signs
  always_comb begin
    sn_nxt = (red_r[4] > ONE_PI);
    cn_nxt = (red_r[4] > HALF_PI) && !(red_r[4] > THREE_HALF_PI);
    if (red_r[4] > THREE_HALF_PI) fx_nxt = TWO_PI - red_r[4];
    else if (red_r[4] > ONE_PI) fx_nxt = red_r[4] - ONE_PI;
    else if (red_r[4] > HALF_PI) fx_nxt = ONE_PI - red_r[4];
    else fx_nxt = red_r[4];
  end

  // Octant swap
  always_comb begin
    swap_nxt = (fx_r > QUARTER_PI);
    y_nxt    = swap_nxt ? (HALF_PI - fx_r) : fx_r;
  end

  // Round Q.56 to Q.30
  assign rnd = y_r + RED_W'(64'd1 << 25);

  // Stage registers
  always_ff @(posedge clk) begin
    if (en) begin
      req_r[0] <= sctt_req_t'(in_req_type);
      for (int i = 1; i < FRONT_STAGES - 1; i++) req_r[i] <= req_r[i-1];
      neg_r[0] <= ang_neg;
      for (int i = 1; i < 4; i++) neg_r[i] <= neg_r[i-1];
      red_r[0] <= {mag, 30'd0};
      for (int i = 0; i < 3; i++) red_r[i+1] <= red_nxt[i];
      red_r[4] <= rr_nxt;
      fx_r     <= fx_nxt;
      sn_r[0]  <= sn_nxt;
      cn_r[0]  <= cn_nxt;
      sn_r[1]  <= sn_r[0];
      cn_r[1]  <= cn_r[0];
      y_r      <= y_nxt;
      swap_r   <= swap_nxt;
      item_r.req     <= req_r[FRONT_STAGES-2];
      item_r.swap    <= swap_r;
      item_r.sin_neg <= sn_r[1];
      item_r.cos_neg <= cn_r[1];
      item_r.x       <= rnd[X_W+25:26];
    end
  end

endmodule

`default_nettype wire

// ===== hdl/sctt_queue.sv =====
// ----------------------------------------------------------------------------
// sctt_queue
// Short FIFO between front end and back end.
// ----------------------------------------------------------------------------
`default_nettype none

module sctt_queue
  import sctt_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire logic  push,
  input  wire sctt_item_t push_item,
  input  wire logic  pop,
  output sctt_item_t pop_item,
  output logic       full,
  output logic       empty
);

  sctt_item_t        buf_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wp_r, rp_r;
  logic [QCNT_W-1:0] cnt_r;

  assign full     = (cnt_r == QCNT_W'(QUEUE_DEPTH));
  assign empty    = (cnt_r == '0);
  assign pop_item = buf_r[rp_r];

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) wp_r <= wp_r + QPTR_W'(1);
      if (pop) rp_r <= rp_r + QPTR_W'(1);
      if (push && !pop) cnt_r <= cnt_r + QCNT_W'(1);
      else if (pop && !push) cnt_r <= cnt_r - QCNT_W'(1);
    end
  end

  // Storage
  always_ff @(posedge clk) begin
    if (push) buf_r[wp_r] <= push_item;
  end

endmodule

`default_nettype wire

// ===== hdl/sctt_series.sv =====
// ----------------------------------------------------------------------------
// sctt_series
// Back end, first half: powers of x, factorial division by reciprocal,
// alternating sums for both series, then sine and cosine with sign.
// ----------------------------------------------------------------------------
`default_nettype none

module sctt_series
  import sctt_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             en,
  input  wire logic             in_v,
  input  wire sctt_item_t       in_item,
  output logic                  sc_v,
  output sctt_req_t             sc_req,
  output logic [SUM_W-1:0]      sc_sin,
  output logic [SUM_W-1:0]      sc_cos
);

  localparam int T  = SERIES_TERMS;
  localparam int NS = T + 5;

  logic [NS-1:0] v_r;

  // Power chain: stage 0 holds the item, stage 1 x^2, stages 2..T powers
  sctt_item_t                 meta_r [T+1];
  logic [X_W-1:0]             x2_r   [T+1];
  logic [T-1:0][POW_W-1:0]    po_r   [T+1];
  logic [T-1:0][POW_W-1:0]    pe_r   [T+1];

  // Division and sum stages
  sctt_item_t               md1_r, md2_r, ms_r;
  logic [T-1:0][31:0]       oest_r, onsh_r, eest_r, ensh_r;
  logic [T-1:0][POW_W-1:0]  oterm_r, eterm_r;
  logic [SUM_W-1:0]         osum_r, esum_r;
  sctt_req_t                req_o_r;
  logic [SUM_W-1:0]         sin_r, cos_r;

  logic [2*X_W:0]           xx;
  logic [SUM_W-1:0]         osum_nxt, esum_nxt;
  logic [SUM_W-1:0]         sin_m, cos_m;

  // Valid pipeline
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[NS-2:0], in_v};
    end
  end

  // Stage 0 takes the item, stage 1 squares x
  assign xx = (2*X_W+1)'(meta_r[0].x) * (2*X_W+1)'(meta_r[0].x)
              + (2*X_W+1)'(64'd1 << 29);

  always_ff @(posedge clk) begin
    if (en) begin
      meta_r[0] <= in_item;
      meta_r[1] <= meta_r[0];
      x2_r[1]   <= xx[2*X_W-1:30];
      po_r[1]   <= {{((T-1)*POW_W){1'b0}}, POW_W'(meta_r[0].x)};
      pe_r[1]   <= {{((T-1)*POW_W){1'b0}}, ONE_Q30};
    end
  end

  // Higher powers, one multiply per stage for each chain
  for (genvar j = 1; j < T; j++) begin : g_pow
    logic [POW_W+X_W-1:0] op, ep;
    logic [T-1:0][POW_W-1:0] po_nxt, pe_nxt;
    assign op = (POW_W+X_W)'(po_r[j][j-1]) * (POW_W+X_W)'(x2_r[j])
                + (POW_W+X_W)'(64'd1 << 29);
    assign ep = (POW_W+X_W)'(pe_r[j][j-1]) * (POW_W+X_W)'(x2_r[j])
                + (POW_W+X_W)'(64'd1 << 29);
    always_comb begin
      po_nxt    = po_r[j];
      pe_nxt    = pe_r[j];
      po_nxt[j] = op[POW_W+X_W-1:30];
      pe_nxt[j] = ep[POW_W+X_W-1:30];
    end
    always_ff @(posedge clk) begin
      if (en) begin
        meta_r[j+1] <= meta_r[j];
        x2_r[j+1]   <= x2_r[j];
        po_r[j+1]   <= po_nxt;
        pe_r[j+1]   <= pe_nxt;
      end
    end
  end

  // Division of each term by its factorial: n! = 2^SH * OD,
  // quotient estimate by reciprocal of OD, then one correction
  for (genvar k = 0; k < 2*T; k++) begin : g_div
    localparam int              FN  = (k < T) ? (2*k + 1) : (2*(k - T));
    localparam longint unsigned FV  = fact(FN);
    localparam int              SH  = fact_tz(FN);
    localparam longint unsigned OD  = FV >> SH;
    localparam longint unsigned RC  = (64'd1 << 32) / OD;
    localparam longint unsigned HF  = FV >> 1;

    logic [63:0] n, prod, fix;
    logic [31:0] nsh, est, r, est_in, nsh_in, term;

    assign nsh    = 32'(n >> SH);
    assign prod   = 64'(nsh) * 64'(RC);
    assign est    = (OD == 64'd1) ? nsh : prod[63:32];
    assign fix    = 64'(est_in) * 64'(OD);
    assign r      = nsh_in - fix[31:0];
    assign term   = (r >= 32'(OD)) ? (est_in + 32'd1) : est_in;

    if (k < T) begin : g_odd
      assign n      = 64'(po_r[T][k]) + 64'(HF);
      assign est_in = oest_r[k];
      assign nsh_in = onsh_r[k];
      always_ff @(posedge clk) begin
        if (en) begin
          oest_r[k]  <= est;
          onsh_r[k]  <= nsh;
          oterm_r[k] <= term[POW_W-1:0];
        end
      end
    end else begin : g_even
      assign n      = 64'(pe_r[T][k-T]) + 64'(HF);
      assign est_in = eest_r[k-T];
      assign nsh_in = ensh_r[k-T];
      always_ff @(posedge clk) begin
        if (en) begin
          eest_r[k-T]  <= est;
          ensh_r[k-T]  <= nsh;
          eterm_r[k-T] <= term[POW_W-1:0];
        end
      end
    end
  end

  // Alternating sums
  always_comb begin
    osum_nxt = '0;
    esum_nxt = '0;
    for (int k = 0; k < T; k++) begin
      if (k % 2 == 1) begin
        osum_nxt = osum_nxt - SUM_W'(oterm_r[k]);
        esum_nxt = esum_nxt - SUM_W'(eterm_r[k]);
      end else begin
        osum_nxt = osum_nxt + SUM_W'(oterm_r[k]);
        esum_nxt = esum_nxt + SUM_W'(eterm_r[k]);
      end
    end
  end

  // Pick the series for each function and apply the quadrant sign
  always_comb begin
    sin_m = ms_r.swap ? esum_r : osum_r;
    cos_m = ms_r.swap ? osum_r : esum_r;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      md1_r   <= meta_r[T];
      md2_r   <= md1_r;
      ms_r    <= md2_r;
      osum_r  <= osum_nxt;
      esum_r  <= esum_nxt;
      req_o_r <= ms_r.req;
      sin_r   <= ms_r.sin_neg ? (SUM_W'(0) - sin_m) : sin_m;
      cos_r   <= ms_r.cos_neg ? (SUM_W'(0) - cos_m) : cos_m;
    end
  end

  assign sc_v   = v_r[NS-1];
  assign sc_req = req_o_r;
  assign sc_sin = sin_r;
  assign sc_cos = cos_r;

endmodule

`default_nettype wire

// ===== hdl/sctt_tan.sv =====
// ----------------------------------------------------------------------------
// sctt_tan
// Back end, second half: pipelined restoring divider for sine over cosine,
// saturation, and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module sctt_tan
  import sctt_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              en,
  input  wire logic              sc_v,
  input  wire sctt_req_t         sc_req,
  input  wire logic [SUM_W-1:0]  sc_sin,
  input  wire logic [SUM_W-1:0]  sc_cos,
  output logic                   res_v,
  output logic [VALUE_W-1:0]     res_value,
  output logic                   res_overflow
);

  localparam int NS = DIV_STAGES + 2;

  typedef struct packed {
    sctt_req_t          req;
    logic               s_neg;
    logic               neg;
    logic               c_zero;
    logic [VALUE_W-1:0] pass;
  } tan_meta_t;

  logic [NS-1:0]     v_r;
  tan_meta_t         meta_r [DIV_STAGES+1];
  logic [MAG_W-1:0]  mc_r   [DIV_STAGES+1];
  logic [MAG_W-1:0]  rem_r  [DIV_STAGES+1];
  logic [NUM_W-1:0]  num_r  [DIV_STAGES+1];
  logic [NUM_W-1:0]  quo_r  [DIV_STAGES+1];
  logic [VALUE_W-1:0] value_r;
  logic              ovf_r;

  logic [MAG_W-1:0]  ms, mc;
  tan_meta_t         m0;
  logic [VALUE_W-1:0] value_nxt;
  logic              ovf_nxt;
  tan_meta_t         ml;
  logic [NUM_W-1:0]  ql;

  // Valid pipeline
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[NS-2:0], sc_v};
    end
  end

  // Magnitudes, signs and pass-through value
  always_comb begin
    ms        = sc_sin[SUM_W-1] ? MAG_W'(SUM_W'(0) - sc_sin) : MAG_W'(sc_sin);
    mc        = sc_cos[SUM_W-1] ? MAG_W'(SUM_W'(0) - sc_cos) : MAG_W'(sc_cos);
    m0.req    = sc_req;
    m0.s_neg  = sc_sin[SUM_W-1];
    m0.neg    = sc_sin[SUM_W-1] ^ sc_cos[SUM_W-1];
    m0.c_zero = (sc_cos == '0);
    case (sc_req)
      REQ_SIN: m0.pass = {{(VALUE_W-SUM_W){sc_sin[SUM_W-1]}}, sc_sin};
      REQ_COS: m0.pass = {{(VALUE_W-SUM_W){sc_cos[SUM_W-1]}}, sc_cos};
      default: m0.pass = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (en) begin
      meta_r[0] <= m0;
      mc_r[0]   <= mc;
      rem_r[0]  <= '0;
      num_r[0]  <= {ms, 30'd0} + NUM_W'(mc >> 1);
      quo_r[0]  <= '0;
    end
  end

  // Divider stages, DIV_STEP quotient bits each
  for (genvar i = 0; i < DIV_STAGES; i++) begin : g_div
    logic [MAG_W-1:0] rem_nxt;
    logic [NUM_W-1:0] num_nxt, quo_nxt;

    always_comb begin
      logic [MAG_W:0] rw;
      rem_nxt = rem_r[i];
      num_nxt = num_r[i];
      quo_nxt = quo_r[i];
      for (int j = 0; j < DIV_STEP; j++) begin
        rw      = {rem_nxt, num_nxt[NUM_W-1]};
        num_nxt = num_nxt << 1;
        if (rw >= {1'b0, mc_r[i]}) begin
          rw      = rw - {1'b0, mc_r[i]};
          quo_nxt = {quo_nxt[NUM_W-2:0], 1'b1};
        end else begin
          quo_nxt = {quo_nxt[NUM_W-2:0], 1'b0};
        end
        rem_nxt = rw[MAG_W-1:0];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        meta_r[i+1] <= meta_r[i];
        mc_r[i+1]   <= mc_r[i];
        rem_r[i+1]  <= rem_nxt;
        num_r[i+1]  <= num_nxt;
        quo_r[i+1]  <= quo_nxt;
      end
    end
  end

  // Result select and saturation
  always_comb begin
    ml = meta_r[DIV_STAGES];
    ql = quo_r[DIV_STAGES];
    value_nxt = ml.pass;
    ovf_nxt   = 1'b0;
    if (ml.req == REQ_TAN) begin
      if (ml.c_zero) begin
        value_nxt = ml.s_neg ? VAL_MIN : VAL_MAX;
        ovf_nxt   = 1'b1;
      end else if (ql > NUM_W'(VAL_MAX)) begin
        value_nxt = ml.neg ? VAL_MIN : VAL_MAX;
        ovf_nxt   = 1'b1;
      end else begin
        value_nxt = ml.neg ? (VALUE_W'(0) - ql[VALUE_W-1:0]) : ql[VALUE_W-1:0];
      end
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (en) begin
      value_r <= value_nxt;
      ovf_r   <= ovf_nxt;
    end
  end

  assign res_v        = v_r[NS-1];
  assign res_value    = value_r;
  assign res_overflow = ovf_r;

endmodule

`default_nettype wire

// ===== hdl/sine_cosine_tangent_taylor.sv =====
// ----------------------------------------------------------------------------
// sine_cosine_tangent_taylor
// Fixed-point sine, cosine and tangent by four-term Taylor series.
// ----------------------------------------------------------------------------
// Takes a Q5.26 angle and a request (sine, cosine, tangent) and returns one
// Q17.30 result with an overflow flag for a saturated tangent. A new item is
// accepted every cycle when the result side keeps up. An item passes the
// front end, the queue, the series stages and the divider stages in that
// order; the pipelined restoring divider for the tangent, two quotient bits
// per stage, holds the most stages. The front end and back end stall
// independently; the four-entry queue between them absorbs the difference.
// ----------------------------------------------------------------------------
`default_nettype none

module sine_cosine_tangent_taylor
  import sctt_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire logic [1:0]          in_req_type,
  input  wire logic [ANGLE_W-1:0]  in_angle,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output logic [VALUE_W-1:0]       out_value,
  output logic                     out_overflow
);

  logic             push, pop, q_full, q_empty, be_en;
  sctt_item_t       push_item, pop_item;
  logic             sc_v;
  sctt_req_t        sc_req;
  logic [SUM_W-1:0] sc_sin, sc_cos;

  // Back end advances whenever the result register is free or being taken
  assign be_en = !out_valid || out_ready;
  assign pop   = be_en && !q_empty;

  sctt_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_req_type (in_req_type),
    .in_angle    (in_angle),
    .q_full      (q_full),
    .push        (push),
    .push_item   (push_item)
  );

  sctt_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_item (push_item),
    .pop       (pop),
    .pop_item  (pop_item),
    .full      (q_full),
    .empty     (q_empty)
  );

  sctt_series u_series (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (be_en),
    .in_v    (pop),
    .in_item (pop_item),
    .sc_v    (sc_v),
    .sc_req  (sc_req),
    .sc_sin  (sc_sin),
    .sc_cos  (sc_cos)
  );

  sctt_tan u_tan (
    .clk          (clk),
    .rst_n        (rst_n),
    .en           (be_en),
    .sc_v         (sc_v),
    .sc_req       (sc_req),
    .sc_sin       (sc_sin),
    .sc_cos       (sc_cos),
    .res_v        (out_valid),
    .res_value    (out_value),
    .res_overflow (out_overflow)
  );

endmodule

`default_nettype wire

// ===== sim/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the sine / cosine / tangent unit: a predictor built
// on 64-bit fixed-point arithmetic computes each expected value and overflow
// flag; a driver and monitor exercise the valid/ready handshakes under random
// idling and one long result-side hold-off.
// ----------------------------------------------------------------------------
module tb_top;
  import sctt_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    sctt_req_t   req;
    logic [31:0] angle;
  } trig_item_t;

  typedef struct {
    logic [VALUE_W-1:0] value;
    logic               overflow;
  } trig_result_t;

  localparam longint unsigned HPI = 64'h3243F6A8885A308D + 64'd16 >> 5;
  localparam longint unsigned QPI = HPI >> 1;
  localparam longint unsigned PI1 = HPI * 2;
  localparam longint unsigned PI3H = HPI * 3;
  localparam longint unsigned PI2 = HPI * 4;
  localparam longint unsigned Q30_ONE = 64'd1 << 30;
  localparam longint unsigned Q30_HALF = 64'd1 << 29;
  localparam longint signed   SAT_HI = (64'sd1 <<< 47) - 1;
  localparam longint signed   SAT_LO = -(64'sd1 <<< 47);

  logic clk, rst_n;
  logic in_valid, in_ready, out_valid, out_ready, out_overflow;
  logic [1:0] in_req_type;
  logic [ANGLE_W-1:0] in_angle;
  logic [VALUE_W-1:0] out_value;
  logic in_ready_q;

  trig_item_t   pending_items[$];
  trig_result_t expected_results[$];
  int  errors = 0;
  int  send_idle_pct, recv_idle_pct;
  int  hold_cycles = 0;
  bit  stim_done = 0;

  sine_cosine_tangent_taylor dut (.*);

  initial begin
    clk = 0;
    forever #1 clk = ~clk;
  end

  initial begin
    #20ms;
    $display("RESULT: ERROR");
    $finish;
  end

  // Taylor sum over a Q.56 first-octant angle, result in Q.30
  function automatic longint signed taylor_sum(longint unsigned x56, bit odd);
    longint unsigned x, x2, p, f, fac;
    longint signed   acc;
    int              n;
    x = (x56 + (64'd1 << 25)) >> 26;
    x2 = (x * x + Q30_HALF) >> 30;
    p = odd ? x : Q30_ONE;
    acc = 0;
    for (int k = 0; k < SERIES_TERMS; k++) begin
      n = 2 * k + (odd ? 1 : 0);
      fac = 1;
      for (int i = 2; i <= n; i++) fac = fac * i;
      f = (p + fac / 2) / fac;
      if (k & 1) acc -= longint'(f);
      else acc += longint'(f);
      p = (p * x2 + Q30_HALF) >> 30;
    end
    return acc;
  endfunction

  // Quadrant fold; cos_mode selects cosine signs and series parity
  function automatic longint signed folded_trig(longint unsigned r, bit cos_mode);
    longint unsigned x;
    bit              neg;
    longint signed   m;
    x = r;
    neg = 0;
    if (r > PI3H) begin
      x = PI2 - r; neg = !cos_mode;
    end else if (r > PI1) begin
      x = r - PI1; neg = 1;
    end else if (r > HPI) begin
      x = PI1 - r; neg = cos_mode;
    end
    if (x > QPI) m = taylor_sum(HPI - x, cos_mode);
    else m = taylor_sum(x, !cos_mode);
    return neg ? -m : m;
  endfunction

  function automatic trig_result_t predict_trig(trig_item_t it);
    trig_result_t    res;
    longint unsigned mag, r, ms, mc, q;
    longint signed   s, c, v;
    bit              neg;
    mag = it.angle[31] ? (64'h1_0000_0000 - {32'd0, it.angle}) : {32'd0, it.angle};
    r = (mag << 30) % PI2;
    if (it.angle[31] && r != 0) r = PI2 - r;
    v = 0;
    res.overflow = 0;
    case (it.req)
      REQ_SIN: v = folded_trig(r, 0);
      REQ_COS: v = folded_trig(r, 1);
      REQ_TAN: begin
        s = folded_trig(r, 0);
        c = folded_trig(r, 1);
        neg = (s < 0) != (c < 0);
        ms = s < 0 ? -s : s;
        mc = c < 0 ? -c : c;
        if (mc == 0) begin
          v = s < 0 ? SAT_LO : SAT_HI;
          res.overflow = 1;
        end else begin
          q = ((ms << 30) + mc / 2) / mc;
          if (q > SAT_HI) begin
            v = neg ? SAT_LO : SAT_HI;
            res.overflow = 1;
          end else v = neg ? -longint'(q) : longint'(q);
        end
      end
      default: v = 0;
    endcase
    res.value = v[VALUE_W-1:0];
    return res;
  endfunction

  function automatic logic [31:0] rand_angle();
    case ($urandom_range(0, 5))
      0: return $urandom;
      1: return $urandom_range(0, 32'h1A00_0000);            // within about +6.5
      2: return -$urandom_range(0, 32'h1A00_0000);
      3: return 32'h0648_7ED5 * $urandom_range(0, 8) + $urandom_range(0, 8) - 4;
      4: return -(32'h0648_7ED5 * $urandom_range(0, 8)) + $urandom_range(0, 8) - 4;
      default: return $urandom_range(0, 32'hFFF);
    endcase
  endfunction

  // Driver: new payload at falling edge once the previous item was taken
  always @(negedge clk) begin
    trig_item_t it;
    if (!rst_n) begin
      in_valid <= 0;
    end else if (!in_valid || in_ready_q) begin
      if (pending_items.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        it = pending_items.pop_front();
        in_req_type <= it.req;
        in_angle <= it.angle;
        in_valid <= 1;
      end else begin
        in_valid <= 0;
      end
    end
  end

  // Handshake seen at the last rising edge
  always @(posedge clk) begin
    trig_item_t it;
    in_ready_q <= 0;
    if (rst_n && in_valid && in_ready) begin
      in_ready_q <= 1;
      it.req = sctt_req_t'(in_req_type);
      it.angle = in_angle;
      expected_results.push_back(predict_trig(it));
    end
  end

  // Receiver ready; long hold-off when requested
  always @(negedge clk) begin
    if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      out_ready <= 0;
    end else begin
      out_ready <= $urandom_range(0, 99) >= recv_idle_pct;
    end
  end

  // Monitor
  always @(posedge clk) begin
    trig_result_t want;
    if (rst_n && out_valid && out_ready) begin
      if (expected_results.size() == 0) begin
        $error("unexpected result value=%h", out_value);
        errors++;
      end else begin
        want = expected_results.pop_front();
        if (out_value !== want.value) begin
          $error("value: expected %h actual %h", want.value, out_value);
          errors++;
        end
        if (out_overflow !== want.overflow) begin
          $error("overflow: expected %b actual %b", want.overflow, out_overflow);
          errors++;
        end
      end
    end
  end

  task automatic queue_item(sctt_req_t r, logic [31:0] a);
    trig_item_t it;
    it.req = r;
    it.angle = a;
    pending_items.push_back(it);
  endtask

  task automatic queue_random(int n);
    for (int i = 0; i < n; i++) queue_item(sctt_req_t'($urandom_range(0, 3)), rand_angle());
  endtask

  task automatic drain_items();
    while (pending_items.size() > 0 || in_valid) @(posedge clk);
  endtask

  initial begin
    logic [31:0] dir_angles[8];
    int          waited;
    rst_n = 0;
    in_valid = 0;
    in_req_type = 0;
    in_angle = 0;
    out_ready = 0;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    dir_angles = '{32'h0, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0001,
                   32'hFFFF_FFFF, 32'h0648_7ED5, 32'h0C90_FDAA, 32'h0324_3F6A};
    repeat (3) @(posedge clk);
    rst_n <= 1;

    // directed: extremes, quadrant edges, every request code
    foreach (dir_angles[i])
      for (int r = 0; r < 3; r++) queue_item(sctt_req_t'(r), dir_angles[i]);
    queue_item(REQ_NONE, 32'h1234_5678);

    send_idle_pct = 11;
    recv_idle_pct = 80;
    queue_random(550);
    drain_items();

    send_idle_pct = 80;
    recv_idle_pct = 11;
    queue_random(550);
    drain_items();

    // back-pressure: receiver stalls long while sender keeps offering
    send_idle_pct = 0;
    recv_idle_pct = 0;
    @(negedge clk);
    hold_cycles = 300;
    queue_random(525);
    drain_items();

    waited = 0;
    while (expected_results.size() > 0 && waited < 100000) begin
      @(posedge clk);
      waited++;
    end
    repeat (100) @(posedge clk);
    if (errors == 0 && expected_results.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end
endmodule
